[rtl/ort_pkg.sv]
`default_nettype none
package ort_pkg;

  // action codes
  localparam logic [2:0] ACT_ADD     = 3'd0;
  localparam logic [2:0] ACT_EXEC    = 3'd1;
  localparam logic [2:0] ACT_EXEC_PX = 3'd2;
  localparam logic [2:0] ACT_CANCEL  = 3'd3;
  localparam logic [2:0] ACT_DELETE  = 3'd4;
  localparam logic [2:0] ACT_REPLACE = 3'd5;

  // result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [2:0] STAT_PRESENT   = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd4;

  // one table slot as stored in memory
  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [31:0] price;
    logic [31:0] shares;
  } slot_t;

endpackage
`default_nettype wire

[rtl/ort_if.sv]
`default_nettype none
// order item channel
interface ort_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [63:0] order_ref;
  logic [63:0] new_order_ref;
  logic [31:0] share_count;
  logic [31:0] limit_price;

  modport source (output valid, action, order_ref, new_order_ref, share_count, limit_price,
                  input ready);
  modport sink (input valid, action, order_ref, new_order_ref, share_count, limit_price,
                output ready);
endinterface

// result channel
interface ort_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] entry_price;
  logic        order_removed;

  modport source (output valid, status, entry_price, order_removed, input ready);
  modport sink (input valid, status, entry_price, order_removed, output ready);
endinterface
`default_nettype wire

[rtl/ort_ram.sv]
`default_nettype none
module ort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/order_reference_table.sv]
// Order reference table: keeps up to TABLE_ENTRIES live orders (key, price,
// outstanding shares) in one on-chip memory and applies add, execute, cancel,
// delete and replace actions, one result per item. After the input transfer
// the scan state reads the slots one per cycle through the memory's single
// read port to find the key, the new key and the first free slot, the last
// state compares the last slot, and the finish state decides and writes back
// once the output register is free. The next item may be taken in the cycle
// after that, so a new item is only accepted once the previous one is done.
// After reset a clearing pass empties the table before the first item is
// taken. A finished result waits in an output register while the next item
// is scanned.
`default_nettype none
module order_reference_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ort_in_if.sink    in_chan,
  ort_out_if.source out_chan
);
  import ort_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam int SW = $bits(slot_t);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_LAST, S_FIN} state_t;

  state_t        state_r;
  logic [IW-1:0] cnt_r;
  logic          pv_r;
  logic [IW-1:0] pidx_r;

  // latched item
  logic [2:0]  action_r;
  logic [63:0] key_r;
  logic [63:0] nkey_r;
  logic [31:0] shares_r;
  logic [31:0] price_r;

  // scan findings
  logic          hit_r;
  logic [IW-1:0] hidx_r;
  slot_t         hs_r;
  logic          nk_r;
  logic          free_r;
  logic [IW-1:0] fidx_r;

  // result register
  logic        out_valid_r;
  logic [2:0]  status_r;
  logic [31:0] price_out_r;
  logic        removed_r;

  logic [SW-1:0] rdata;
  slot_t         rd_slot;
  logic          we;
  logic [IW-1:0] waddr;
  slot_t         wslot;
  logic [2:0]    status_nxt;
  logic [31:0]   price_nxt;
  logic          removed_nxt;
  logic          dec_we;
  logic [IW-1:0] dec_addr;
  slot_t         dec_slot;
  logic [31:0]   rem;
  logic          fin_go;

  assign rd_slot = slot_t'(rdata);
  assign fin_go  = (state_r == S_FIN) && (!out_valid_r || out_chan.ready);
  assign rem     = hs_r.shares - shares_r;

  ort_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wslot),
    .raddr (cnt_r),
    .rdata (rdata)
  );

  // decide result and write-back from scan findings
  always_comb begin
    status_nxt  = STAT_NOT_FOUND;
    price_nxt   = '0;
    removed_nxt = 1'b0;
    dec_we      = 1'b0;
    dec_addr    = hidx_r;
    dec_slot    = hs_r;
    unique case (action_r)
      ACT_ADD: begin
        if (hit_r) begin
          status_nxt = STAT_PRESENT;
        end else if (!free_r) begin
          status_nxt = STAT_FULL;
        end else begin
          status_nxt = STAT_OK;
          price_nxt  = price_r;
          dec_we     = 1'b1;
          dec_addr   = fidx_r;
          dec_slot   = '{valid: 1'b1, key: key_r, price: price_r, shares: shares_r};
        end
      end
      ACT_EXEC, ACT_EXEC_PX, ACT_CANCEL: begin
        if (!hit_r) begin
          status_nxt = STAT_NOT_FOUND;
        end else if (shares_r > hs_r.shares) begin
          status_nxt = STAT_UNDERFLOW;
        end else begin
          status_nxt      = STAT_OK;
          price_nxt       = hs_r.price;
          removed_nxt     = (rem == '0);
          dec_we          = 1'b1;
          dec_slot.shares = rem;
          dec_slot.valid  = (rem != '0);
        end
      end
      ACT_DELETE: begin
        if (hit_r) begin
          status_nxt     = STAT_OK;
          price_nxt      = hs_r.price;
          removed_nxt    = 1'b1;
          dec_we         = 1'b1;
          dec_slot.valid = 1'b0;
        end
      end
      ACT_REPLACE: begin
        if (!hit_r) begin
          status_nxt = STAT_NOT_FOUND;
        end else if (nk_r) begin
          status_nxt = STAT_PRESENT;
        end else begin
          status_nxt = STAT_OK;
          price_nxt  = price_r;
          dec_we     = 1'b1;
          dec_slot   = '{valid: 1'b1, key: nkey_r, price: price_r, shares: shares_r};
        end
      end
      default: begin
        status_nxt = STAT_NOT_FOUND;
      end
    endcase
  end

  // memory write: clearing pass or write-back
  always_comb begin
    if (state_r == S_CLEAR) begin
      we    = 1'b1;
      waddr = cnt_r;
      wslot = '0;
    end else begin
      we    = fin_go && dec_we;
      waddr = dec_addr;
      wslot = dec_slot;
    end
  end

  // sequencer, scan findings and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r   <= (state_r == S_SCAN);
      pidx_r <= cnt_r;

      // compare the slot read in the previous cycle
      if (pv_r) begin
        if (rd_slot.valid && rd_slot.key == key_r && !hit_r) begin
          hit_r  <= 1'b1;
          hidx_r <= pidx_r;
          hs_r   <= rd_slot;
        end
        if (rd_slot.valid && rd_slot.key == nkey_r) begin
          nk_r <= 1'b1;
        end
        if (!rd_slot.valid && !free_r) begin
          free_r <= 1'b1;
          fidx_r <= pidx_r;
        end
      end

      if (out_valid_r && out_chan.ready && !fin_go) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          if (cnt_r == LAST_IDX) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            action_r <= in_chan.action;
            key_r    <= in_chan.order_ref;
            nkey_r   <= in_chan.new_order_ref;
            shares_r <= in_chan.share_count;
            price_r  <= in_chan.limit_price;
            hit_r    <= 1'b0;
            nk_r     <= 1'b0;
            free_r   <= 1'b0;
            cnt_r    <= '0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r == LAST_IDX) begin
            state_r <= S_LAST;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_LAST: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r <= 1'b1;
            status_r    <= status_nxt;
            price_out_r <= price_nxt;
            removed_r   <= removed_nxt;
            cnt_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = status_r;
  assign out_chan.entry_price   = price_out_r;
  assign out_chan.order_removed = removed_r;

endmodule
`default_nettype wire

[sim/order_reference_table_tb_if.sv]
`default_nettype none
// item and result records shared by the testbench
package order_reference_table_tb_pkg;
  import ort_pkg::*;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] order_ref;
    logic [63:0] new_order_ref;
    logic [31:0] share_count;
    logic [31:0] limit_price;
  } order_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_price;
    logic        order_removed;
  } order_result_t;
endpackage
`default_nettype wire

[sim/order_reference_table_tb.sv]
`default_nettype none
module order_reference_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ort_pkg::*;
  import order_reference_table_tb_pkg::*;

  localparam int ENTRIES = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  int   errors = 0;
  int   stall_cycles = 0;

  ort_in_if  in_chan ();
  ort_out_if out_chan ();

  order_reference_table #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // own copy of the order table
  logic        tbl_valid [ENTRIES];
  logic [63:0] tbl_key   [ENTRIES];
  logic [31:0] tbl_price [ENTRIES];
  logic [31:0] tbl_shares[ENTRIES];
  order_result_t pending_results[$];
  logic [63:0]   live_keys[$];

  function automatic int lookup_slot(logic [63:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++) n += tbl_valid[i];
    return n;
  endfunction

  // apply one order action to the table and give the expected result
  function automatic order_result_t apply_order(order_item_t it);
    order_result_t r;
    int s;
    int f;
    r = '{status: STAT_NOT_FOUND, entry_price: '0, order_removed: 1'b0};
    case (it.action)
      ACT_ADD: begin
        if (lookup_slot(it.order_ref) >= 0) begin
          r.status = STAT_PRESENT;
        end else begin
          f = -1;
          for (int i = ENTRIES - 1; i >= 0; i--) if (!tbl_valid[i]) f = i;
          if (f < 0) begin
            r.status = STAT_FULL;
          end else begin
            tbl_valid[f] = 1'b1;
            tbl_key[f] = it.order_ref;
            tbl_price[f] = it.limit_price;
            tbl_shares[f] = it.share_count;
            r.status = STAT_OK;
            r.entry_price = it.limit_price;
          end
        end
      end
      ACT_EXEC, ACT_EXEC_PX, ACT_CANCEL: begin
        s = lookup_slot(it.order_ref);
        if (s < 0) begin
          r.status = STAT_NOT_FOUND;
        end else if (it.share_count > tbl_shares[s]) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.status = STAT_OK;
          r.entry_price = tbl_price[s];
          tbl_shares[s] -= it.share_count;
          if (tbl_shares[s] == 0) begin
            tbl_valid[s] = 1'b0;
            r.order_removed = 1'b1;
          end
        end
      end
      ACT_DELETE: begin
        s = lookup_slot(it.order_ref);
        if (s >= 0) begin
          r.status = STAT_OK;
          r.entry_price = tbl_price[s];
          tbl_valid[s] = 1'b0;
          r.order_removed = 1'b1;
        end
      end
      ACT_REPLACE: begin
        s = lookup_slot(it.order_ref);
        if (s < 0) begin
          r.status = STAT_NOT_FOUND;
        end else if (lookup_slot(it.new_order_ref) >= 0) begin
          r.status = STAT_PRESENT;
        end else begin
          tbl_key[s] = it.new_order_ref;
          tbl_price[s] = it.limit_price;
          tbl_shares[s] = it.share_count;
          r.status = STAT_OK;
          r.entry_price = it.limit_price;
        end
      end
      default: r.status = STAT_NOT_FOUND;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  // drive one item until its transfer, with random idle cycles before it
  task automatic send_order(order_item_t it);
    while (!calm && $urandom_range(99) < 18) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.action        <= it.action;
    in_chan.order_ref     <= it.order_ref;
    in_chan.new_order_ref <= it.new_order_ref;
    in_chan.share_count   <= it.share_count;
    in_chan.limit_price   <= it.limit_price;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.insert(pending_results.size(), apply_order(it));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic order_item_t mk(logic [2:0] a, logic [63:0] k, logic [63:0] nk,
                                     logic [31:0] sh, logic [31:0] px);
    return '{action: a, order_ref: k, new_order_ref: nk, share_count: sh, limit_price: px};
  endfunction

  // key that is live in the table, else a fresh one
  function automatic logic [63:0] pick_key();
    int s;
    for (int t = 0; t < 8; t++) begin
      s = $urandom_range(ENTRIES - 1);
      if (tbl_valid[s]) return tbl_key[s];
    end
    return rand64();
  endfunction

  // result checker with random back-pressure
  always @(posedge clk) begin
    order_result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_chan.status), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_chan.status !== want.status)
            report_mismatch("status", 64'(out_chan.status), 64'(want.status));
          if (out_chan.entry_price !== want.entry_price)
            report_mismatch("entry_price", 64'(out_chan.entry_price),
                            64'(want.entry_price));
          if (out_chan.order_removed !== want.order_removed)
            report_mismatch("order_removed", 64'(out_chan.order_removed),
                            64'(want.order_removed));
        end
      end
      out_chan.ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("order_reference_table_tb NOT OK");
      $finish;
    end
  end

  // boundary values of every field and the not-found, present and underflow paths
  task automatic test_directed();
    send_order(mk(ACT_DELETE, 64'd0, 64'd0, 32'd0, 32'd0));
    send_order(mk(ACT_ADD, 64'd0, '1, 32'd0, 32'd0));
    send_order(mk(ACT_ADD, '1, '0, '1, '1));
    send_order(mk(ACT_ADD, '1, '0, 32'd5, 32'd7));
    send_order(mk(ACT_EXEC, '1, '0, 32'd100, 32'd0));
    send_order(mk(ACT_EXEC_PX, '1, '1, 32'hFFFF_FFF0, '1));
    send_order(mk(ACT_CANCEL, '1, '1, '1, '0));
    send_order(mk(ACT_CANCEL, '1, '1, 32'd15, '0));
    send_order(mk(ACT_EXEC, 64'd0, '0, 32'd0, '0));
    send_order(mk(ACT_ADD, 64'd10, '0, 32'd3, 32'd9));
    send_order(mk(ACT_REPLACE, 64'd10, 64'd10, 32'd1, 32'd1));
    send_order(mk(ACT_REPLACE, 64'd11, 64'd12, 32'd1, 32'd1));
    send_order(mk(ACT_REPLACE, 64'd10, 64'hAAAA_5555_AAAA_5555, 32'd0, '1));
    send_order(mk(ACT_CANCEL, 64'hAAAA_5555_AAAA_5555, '0, 32'd0, '0));
    send_order(mk(ACT_DELETE, 64'hAAAA_5555_AAAA_5555, '0, '1, '0));
    send_order(mk(3'd6, 64'd0, '0, 32'd0, '0));
    send_order(mk(3'd7, '1, '1, '1, '1));
  endtask

  // fill the table to overflow, then drain it
  task automatic test_table_full();
    while (live_count() < ENTRIES) send_order(mk(ACT_ADD, rand64(), '0, $urandom, $urandom));
    send_order(mk(ACT_ADD, rand64(), '0, 32'd1, 32'd1));
    send_order(mk(ACT_ADD, tbl_key[3], '0, 32'd1, 32'd1));
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i]) send_order(mk(ACT_DELETE, tbl_key[i], '0, $urandom, '0));
  endtask

  // mostly valid order traffic with random content, some noise
  task automatic test_random_traffic(int count);
    order_item_t it;
    logic [63:0] k;
    int s;
    for (int n = 0; n < count; n++) begin
      calm = (n >= count / 2 && n < count / 2 + 200);
      k = pick_key();
      s = lookup_slot(k);
      it = mk(3'($urandom_range(5)), k, pick_key(), $urandom, $urandom);
      if ($urandom_range(99) < 5) it.action = 3'($urandom_range(7));
      if (live_count() < 40 && $urandom_range(2) == 0) begin
        it.action = ACT_ADD;
        if ($urandom_range(9) != 0) it.order_ref = rand64();
      end
      if ($urandom_range(3) != 0) it.new_order_ref = rand64();
      // keep share counts small so executes often hit or finish orders
      case ($urandom_range(3))
        0: it.share_count = $urandom_range(20);
        1: if (s >= 0) it.share_count = tbl_shares[s];
        2: if (s >= 0) it.share_count = $urandom_range(tbl_shares[s] > 50 ? 50 :
                                                     tbl_shares[s]);
        default: ;
      endcase
      send_order(it);
    end
    calm = 1'b0;
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.action = ACT_ADD;
    in_chan.order_ref = '0;
    in_chan.new_order_ref = '0;
    in_chan.share_count = '0;
    in_chan.limit_price = '0;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random_traffic(1550);
    test_table_full();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 20) @(posedge clk);
    if (errors == 0)
      $display("order_reference_table_tb OK");
    else
      $display("order_reference_table_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
